// File: design/kshu_pkg.sv
// ============================================================================
// kshu_pkg
// Shared types, constants and functions for the Keccak-256 stream hash unit.
// ============================================================================
package kshu_pkg;

    localparam int NUM_LANES        = 25;
    localparam int LANE_W           = 64;

    localparam int RATE_BYTES_DEF   = 136;
    localparam int NUM_ROUNDS_DEF   = 24;
    localparam int DIGEST_WORDS_DEF = 4;

    localparam logic [7:0] PAD_FIRST = 8'h01;
    localparam logic [7:0] PAD_LAST  = 8'h80;
    localparam logic [7:0] LFSR_INIT = 8'h01;
    // Low byte of the feedback polynomial 0x171 after the carry bit drops out.
    localparam logic [7:0] LFSR_TAPS = 8'h71;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef logic [LANE_W-1:0]                t_lane;
    typedef logic [NUM_LANES-1:0][LANE_W-1:0] t_state;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PERM = 3'b010,
        ST_EMIT = 3'b100
    } t_seq_state;

    typedef struct packed {
        logic insert;   // XOR the byte at the fill position
        logic pad;      // also XOR the closing pad bit at the end of the rate
        logic round;    // apply one permutation round
        logic clear;    // zero the whole state
    } t_sponge_ctrl;

    localparam int RHO [NUM_LANES] = '{
        0, 1, 62, 28, 27,
        36, 44, 6, 55, 20,
        3, 10, 43, 25, 39,
        41, 45, 15, 21, 8,
        18, 2, 61, 56, 14
    };

    function automatic t_lane rotl64(input t_lane v, input int n);
        t_lane r;
        begin
            if (n % LANE_W == 0) begin
                r = v;
            end else begin
                r = (v << (n % LANE_W)) | (v >> (LANE_W - (n % LANE_W)));
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] lfsr_step(input logic [7:0] l);
        logic [7:0] s;
        begin
            s = {l[6:0], 1'b0};
            if (l[7]) begin
                s = s ^ LFSR_TAPS;
            end
            return s;
        end
    endfunction

    // Seven LFSR outputs land on round constant bits 0, 1, 3, 7, 15, 31 and 63.
    function automatic t_lane round_const(input logic [7:0] lfsr);
        logic [7:0] l;
        t_lane      rc;
        begin
            l  = lfsr;
            rc = '0;
            for (int j = 0; j < 7; j++) begin
                if (l[0]) begin
                    rc[(1 << j) - 1] = 1'b1;
                end
                l = lfsr_step(l);
            end
            return rc;
        end
    endfunction

    function automatic logic [7:0] lfsr_advance(input logic [7:0] lfsr);
        logic [7:0] l;
        begin
            l = lfsr;
            for (int j = 0; j < 7; j++) begin
                l = lfsr_step(l);
            end
            return l;
        end
    endfunction

endpackage

// File: design/keccak256_stream_hash_unit.sv
// ============================================================================
// keccak256_stream_hash_unit
// Streaming Keccak-256 (original 0x01 padding) with a one-round-per-cycle core.
// ============================================================================
// Input channel (s_axis): each transfer carries one command in tuser and one
// message byte in tdata. An absorb transfer XORs the byte into the state;
// the byte that fills the rate block starts the permutation, which runs
// NUM_ROUNDS rounds (24 by default) with tready held low. A finish transfer
// pads the block and permutes, then the digest leaves on m_axis as
// DIGEST_WORDS 64-bit little-endian words, the last one marked with tlast.
// The state is cleared as the last word is loaded. Absorb throughput is set
// by the single shared round unit: no byte is taken while a block permutes.
// The output register holds a word while the receiver stalls; digest
// emission waits for it, and input transfers resume once the last word sits
// in the output register. Synchronous reset zeros the state, the fill
// position and the round counter and drops the output valid.
// ============================================================================
module keccak256_stream_hash_unit #(
    parameter int RATE_BYTES   = kshu_pkg::RATE_BYTES_DEF,
    parameter int NUM_ROUNDS   = kshu_pkg::NUM_ROUNDS_DEF,
    parameter int DIGEST_WORDS = kshu_pkg::DIGEST_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] digest_word
    output logic        o_m_axis_tlast
);

    localparam int WORD_W = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

    kshu_pkg::t_seq_state   r_state, n_state;
    logic [7:0]             r_fill, n_fill;
    logic [4:0]             r_round, n_round;
    logic [7:0]             r_lfsr, n_lfsr;
    logic [WORD_W-1:0]      r_word, n_word;
    logic                   r_finish, n_finish;
    logic                   r_out_valid;
    logic [63:0]            r_out_data;
    logic                   r_out_last;

    kshu_pkg::t_sponge_ctrl w_ctrl;
    kshu_pkg::t_state       w_lanes;
    logic [7:0]             w_byte;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_last_round;
    logic                   w_last_word;

    assign o_s_axis_tready = (r_state == kshu_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last_round    = (r_round == 5'(NUM_ROUNDS - 1));
    assign w_last_word     = (r_word == WORD_W'(DIGEST_WORDS - 1));
    assign w_load          = (r_state == kshu_pkg::ST_EMIT)
                           && (!r_out_valid || i_m_axis_tready);

    // A finish inserts the opening pad byte in place of the message byte.
    assign w_byte = (i_s_axis_tuser == kshu_pkg::CMD_FINISH) ? kshu_pkg::PAD_FIRST
                                                             : i_s_axis_tdata;

    always_comb begin
        w_ctrl.insert = w_accept;
        w_ctrl.pad    = w_accept && (i_s_axis_tuser == kshu_pkg::CMD_FINISH);
        w_ctrl.round  = (r_state == kshu_pkg::ST_PERM);
        w_ctrl.clear  = w_load && w_last_word;
    end

    kshu_sponge #(
        .RATE_BYTES (RATE_BYTES)
    ) u_sponge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_fill  (r_fill),
        .i_byte  (w_byte),
        .i_rc    (kshu_pkg::round_const(r_lfsr)),
        .o_lanes (w_lanes)
    );

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_round  = r_round;
        n_lfsr   = r_lfsr;
        n_word   = r_word;
        n_finish = r_finish;
        case (r_state)
            kshu_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == kshu_pkg::CMD_FINISH) begin
                        n_fill   = '0;
                        n_finish = 1'b1;
                        n_state  = kshu_pkg::ST_PERM;
                    end else if (r_fill + 8'd1 == 8'(RATE_BYTES)) begin
                        n_fill   = '0;
                        n_finish = 1'b0;
                        n_state  = kshu_pkg::ST_PERM;
                    end else begin
                        n_fill = r_fill + 8'd1;
                    end
                end
            end
            kshu_pkg::ST_PERM: begin
                if (w_last_round) begin
                    n_round = '0;
                    n_lfsr  = kshu_pkg::LFSR_INIT;
                    n_state = r_finish ? kshu_pkg::ST_EMIT : kshu_pkg::ST_IDLE;
                end else begin
                    n_round = r_round + 5'd1;
                    n_lfsr  = kshu_pkg::lfsr_advance(r_lfsr);
                end
            end
            kshu_pkg::ST_EMIT: begin
                if (w_load) begin
                    if (w_last_word) begin
                        n_word  = '0;
                        n_state = kshu_pkg::ST_IDLE;
                    end else begin
                        n_word = r_word + WORD_W'(1);
                    end
                end
            end
            default: begin
                n_state = kshu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kshu_pkg::ST_IDLE;
            r_fill   <= '0;
            r_round  <= '0;
            r_lfsr   <= kshu_pkg::LFSR_INIT;
            r_word   <= '0;
            r_finish <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_round  <= n_round;
            r_lfsr   <= n_lfsr;
            r_word   <= n_word;
            r_finish <= n_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_lanes[5'(r_word)];
            r_out_last <= w_last_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // The round counter and LFSR rest at their start values outside a permutation.
    a_round_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kshu_pkg::ST_PERM) |-> (r_round == 5'd0 && r_lfsr == kshu_pkg::LFSR_INIT))
        else $error("round counter or LFSR not at rest outside a permutation");

    // The fill position never reaches the end of the rate block.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < 8'(RATE_BYTES))
        else $error("fill position reached the rate size");

    // A digest word is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_out_valid) |-> i_m_axis_tready)
        else $error("digest word overwritten before transfer");

    // Emission always starts from the first digest word.
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == kshu_pkg::ST_EMIT) |-> (r_word == '0))
        else $error("digest emission did not start at word zero");
`endif

endmodule

// File: design/kshu_round.sv
// ============================================================================
// kshu_round
// One Keccak-f[1600] round: theta, rho, pi, chi and iota.
// ============================================================================
module kshu_round (
    input  kshu_pkg::t_state i_state,
    input  kshu_pkg::t_lane  i_rc,
    output kshu_pkg::t_state o_state
);

    kshu_pkg::t_lane c [5];
    kshu_pkg::t_lane d [5];
    kshu_pkg::t_state a;
    kshu_pkg::t_state b;
    kshu_pkg::t_state x_chi;

    genvar gx, gy;

    generate
        for (gx = 0; gx < 5; gx++) begin : g_col
            localparam int XM1 = (gx + 4) % 5;
            localparam int XP1 = (gx + 1) % 5;
            assign c[gx] = i_state[gx] ^ i_state[gx + 5] ^ i_state[gx + 10]
                         ^ i_state[gx + 15] ^ i_state[gx + 20];
            assign d[gx] = c[XM1] ^ kshu_pkg::rotl64(c[XP1], 1);
        end

        for (gy = 0; gy < 5; gy++) begin : g_row
            for (gx = 0; gx < 5; gx++) begin : g_lane
                localparam int IDX  = gx + 5 * gy;
                localparam int DST  = gy + 5 * ((2 * gx + 3 * gy) % 5);
                localparam int CHI1 = (gx + 1) % 5 + 5 * gy;
                localparam int CHI2 = (gx + 2) % 5 + 5 * gy;
                assign a[IDX]     = i_state[IDX] ^ d[gx];
                assign b[DST]     = kshu_pkg::rotl64(a[IDX], kshu_pkg::RHO[IDX]);
                assign x_chi[IDX] = b[IDX] ^ (~b[CHI1] & b[CHI2]);
            end
        end
    endgenerate

    always_comb begin
        o_state    = x_chi;
        o_state[0] = x_chi[0] ^ i_rc;
    end

endmodule

// File: design/kshu_sponge.sv
// ============================================================================
// kshu_sponge
// The 1600-bit sponge state with byte insertion, padding and the round unit.
// ============================================================================
module kshu_sponge #(
    parameter int RATE_BYTES = kshu_pkg::RATE_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kshu_pkg::t_sponge_ctrl i_ctrl,
    input  logic [7:0]            i_fill,
    input  logic [7:0]            i_byte,
    input  kshu_pkg::t_lane       i_rc,
    output kshu_pkg::t_state      o_lanes
);

    localparam int PAD_LANE  = (RATE_BYTES - 1) / 8;
    localparam int PAD_SHIFT = ((RATE_BYTES - 1) % 8) * 8;

    kshu_pkg::t_state r_lanes;
    kshu_pkg::t_state n_lanes;
    kshu_pkg::t_state w_round;
    kshu_pkg::t_state w_ins;

    kshu_round u_round (
        .i_state (r_lanes),
        .i_rc    (i_rc),
        .o_state (w_round)
    );

    always_comb begin
        for (int i = 0; i < kshu_pkg::NUM_LANES; i++) begin
            if (i_fill[7:3] == 5'(i)) begin
                w_ins[i] = {56'd0, i_byte} << {i_fill[2:0], 3'b000};
            end else begin
                w_ins[i] = '0;
            end
        end
        if (i_ctrl.pad) begin
            w_ins[PAD_LANE] = w_ins[PAD_LANE]
                            ^ ({56'd0, kshu_pkg::PAD_LAST} << PAD_SHIFT);
        end
    end

    always_comb begin
        n_lanes = r_lanes;
        if (i_ctrl.clear) begin
            n_lanes = '0;
        end else if (i_ctrl.round) begin
            n_lanes = w_round;
        end else if (i_ctrl.insert) begin
            n_lanes = r_lanes ^ w_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= '0;
        end else begin
            r_lanes <= n_lanes;
        end
    end

    assign o_lanes = r_lanes;

endmodule

// File: bench/tb_keccak256_stream_hash_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_keccak256_stream_hash_unit
// Self-checking bench for the streaming Keccak-256 unit. A short table of
// directed transfers comes first, then random messages. The random messages
// include one whose pad bytes fall on the last rate byte and one that fills
// a whole block. A local sponge predictor gives the digests the table lacks.
// Both sides idle at random; the receiver stalls once for a long stretch.
// ============================================================================
module tb_keccak256_stream_hash_unit;

    localparam int RANDOM_ITEMS = 345;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef logic [kshu_pkg::DIGEST_WORDS_DEF-1:0][kshu_pkg::LANE_W-1:0] t_digest;

    // Keccak-256 of the empty message, highest word first.
    localparam t_digest EMPTY_DIGEST = {
        64'h70a4855d04d8fa7b, 64'h3b2782ca53b600e5,
        64'hc003c7dcb27d7e92, 64'h3c23f7860146d2c5
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] value;
        logic       known;
        t_digest    digest;
    } t_vector;

    localparam int N_VECTORS = 14;
    localparam t_vector VECTORS [N_VECTORS] = '{
        '{kshu_pkg::CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // empty message after reset
        '{kshu_pkg::CMD_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},   // finish right after a finish
        '{kshu_pkg::CMD_ABSORB, 8'h00, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'hFF, 1'b0, '0},
        '{kshu_pkg::CMD_FINISH, 8'h5A, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'h80, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'h01, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'h55, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'hAA, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'h7F, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'hFE, 1'b0, '0},
        '{kshu_pkg::CMD_FINISH, 8'hA5, 1'b0, '0},
        '{kshu_pkg::CMD_ABSORB, 8'h0F, 1'b0, '0},
        '{kshu_pkg::CMD_FINISH, 8'h00, 1'b0, '0}
    };

    localparam int LANE_ROT [kshu_pkg::NUM_LANES] = '{
        0, 1, 62, 28, 27,
        36, 44, 6, 55, 20,
        3, 10, 43, 25, 39,
        41, 45, 15, 21, 8,
        18, 2, 61, 56, 14
    };

    typedef struct packed {
        logic [kshu_pkg::LANE_W-1:0] word;
        logic                        last;
    } t_digest_beat;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    // Predictor state.
    kshu_pkg::t_lane sponge [kshu_pkg::NUM_LANES];
    int              fill_pos;
    kshu_pkg::t_lane iota_rc [kshu_pkg::NUM_ROUNDS_DEF];

    t_digest_beat pending_words [$];

    int  mismatch_count  = 0;
    int  transfers_in    = 0;
    int  messages_hashed = 0;
    int  words_checked   = 0;
    bit  steady_run      = 1'b0;
    bit  stall_request   = 1'b0;

    keccak256_stream_hash_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [7:0] data_byte
        .i_s_axis_tuser  (s_tuser),     // [0] command
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),     // [63:0] digest_word
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kshu_pkg::t_lane rotl_lane(input kshu_pkg::t_lane v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (kshu_pkg::LANE_W - n)));
    endfunction

    function automatic void keccak_f();
        kshu_pkg::t_lane c [5];
        kshu_pkg::t_lane d [5];
        kshu_pkg::t_lane b [kshu_pkg::NUM_LANES];
        for (int r = 0; r < kshu_pkg::NUM_ROUNDS_DEF; r++) begin
            for (int x = 0; x < 5; x++) begin
                c[x] = sponge[x] ^ sponge[x + 5] ^ sponge[x + 10]
                     ^ sponge[x + 15] ^ sponge[x + 20];
            end
            for (int x = 0; x < 5; x++) begin
                d[x] = c[(x + 4) % 5] ^ rotl_lane(c[(x + 1) % 5], 1);
            end
            for (int y = 0; y < 5; y++) begin
                for (int x = 0; x < 5; x++) begin
                    sponge[x + 5 * y] ^= d[x];
                end
            end
            // Rho and pi together: lane (x, y) moves to (y, 2x + 3y).
            for (int y = 0; y < 5; y++) begin
                for (int x = 0; x < 5; x++) begin
                    b[y + 5 * ((2 * x + 3 * y) % 5)] =
                        rotl_lane(sponge[x + 5 * y], LANE_ROT[x + 5 * y]);
                end
            end
            for (int y = 0; y < 5; y++) begin
                for (int x = 0; x < 5; x++) begin
                    sponge[x + 5 * y] = b[x + 5 * y]
                        ^ (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
                end
            end
            sponge[0] ^= iota_rc[r];
        end
    endfunction

    // Advances the predicted sponge by one input transfer. Returns 1 when the
    // transfer closes a message, with the digest words in digest.
    function automatic bit sponge_step(input logic cmd, input logic [7:0] value,
                                       output t_digest digest);
        digest = '0;
        if (cmd == kshu_pkg::CMD_ABSORB) begin
            sponge[fill_pos / 8] ^= kshu_pkg::t_lane'(value) << (8 * (fill_pos % 8));
            fill_pos++;
            if (fill_pos == kshu_pkg::RATE_BYTES_DEF) begin
                keccak_f();
                fill_pos = 0;
            end
            return 1'b0;
        end
        sponge[fill_pos / 8] ^= kshu_pkg::t_lane'(kshu_pkg::PAD_FIRST) << (8 * (fill_pos % 8));
        sponge[(kshu_pkg::RATE_BYTES_DEF - 1) / 8] ^=
            kshu_pkg::t_lane'(kshu_pkg::PAD_LAST) << (8 * ((kshu_pkg::RATE_BYTES_DEF - 1) % 8));
        keccak_f();
        for (int k = 0; k < kshu_pkg::DIGEST_WORDS_DEF; k++) begin
            digest[k] = sponge[k];
        end
        for (int i = 0; i < kshu_pkg::NUM_LANES; i++) begin
            sponge[i] = '0;
        end
        fill_pos = 0;
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic cmd, input logic [7:0] value,
                             input logic known, input t_digest known_digest);
        t_digest digest;
        while (!steady_run && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'($urandom_range(1));
            s_tdata  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        transfers_in++;
        if (sponge_step(cmd, value, digest)) begin
            messages_hashed++;
            if (known) begin
                digest = known_digest;
            end
            for (int k = 0; k < kshu_pkg::DIGEST_WORDS_DEF; k++) begin
                pending_words.push_back(t_digest_beat'{digest[k],
                                        k == kshu_pkg::DIGEST_WORDS_DEF - 1});
            end
        end
        @(negedge clk);
    endtask

    always @(posedge clk) begin : check_output
        t_digest_beat head;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: digest word with nothing expected, actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                head = pending_words.pop_front();
                words_checked++;
                if (m_tdata !== head.word) begin
                    $display("%0t: digest word mismatch, expected %h actual %h",
                             $time, head.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== head.last) begin
                    $display("%0t: tlast mismatch, expected %b actual %b",
                             $time, head.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver side: random back-pressure, one long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= steady_run || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] lfsr;
        logic [8:0] shifted;
        logic [7:0] value;
        int         msg_len;
        int         msg_idx;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = kshu_pkg::CMD_ABSORB;
        s_tdata  = 8'h00;

        // Iota constants: seven LFSR bits per round land on bits 2^j - 1.
        lfsr = 8'h01;
        for (int r = 0; r < kshu_pkg::NUM_ROUNDS_DEF; r++) begin
            iota_rc[r] = '0;
            for (int j = 0; j < 7; j++) begin
                if (lfsr[0]) begin
                    iota_rc[r][(1 << j) - 1] = 1'b1;
                end
                shifted = {lfsr, 1'b0};
                if (shifted[8]) begin
                    shifted ^= 9'h171;
                end
                lfsr = shifted[7:0];
            end
        end
        for (int i = 0; i < kshu_pkg::NUM_LANES; i++) begin
            sponge[i] = '0;
        end
        fill_pos = 0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_VECTORS; i++) begin
            send_item(VECTORS[i].cmd, VECTORS[i].value, VECTORS[i].known,
                      VECTORS[i].digest);
        end

        msg_idx = 0;
        while (transfers_in < N_VECTORS + RANDOM_ITEMS) begin
            case (msg_idx)
                // Both pad bytes fall on the last byte of the rate.
                0: msg_len = kshu_pkg::RATE_BYTES_DEF - 1;
                // A full block permutes on absorb; the finish then pads at byte 0.
                1: msg_len = kshu_pkg::RATE_BYTES_DEF;
                default: begin
                    if ($urandom_range(99) < 75) begin
                        msg_len = $urandom_range(12);
                    end else begin
                        msg_len = $urandom_range(40, 13);
                    end
                end
            endcase
            steady_run = (msg_idx >= 1 && msg_idx <= 4);
            if (msg_idx == 8) begin
                stall_request = 1'b1;
            end
            for (int n = 0; n < msg_len; n++) begin
                case ($urandom_range(9))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    default: value = 8'($urandom_range(255));
                endcase
                send_item(kshu_pkg::CMD_ABSORB, value, 1'b0, '0);
            end
            send_item(kshu_pkg::CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
            msg_idx++;
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d input transfers, including a full block",
                 messages_hashed, transfers_in);
        $display("and a last-byte pad; %0d digest words checked under back-pressure.",
                 words_checked);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("%0t: timeout with %0d digest words outstanding",
                 $time, pending_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: keccak256_stream_hash_unit.f
design/kshu_pkg.sv
design/kshu_round.sv
design/kshu_sponge.sv
design/keccak256_stream_hash_unit.sv
bench/tb_keccak256_stream_hash_unit.sv
